[hw/rtl/twegh_pkg.sv]
// Shared types, constants and codes for the gated time-window histogram block.
package twegh_pkg;

    localparam int E_W   = 14;   // energy, time and register width
    localparam int IDX_W = 8;    // read index width
    localparam int VAL_W = 20;   // window counter and read value width
    localparam int BIN_W = 15;   // time histogram bin width
    localparam int HIT_W = 4;    // reported window index width
    localparam int CFG_IDX_W = 3;

    localparam int NUM_WINDOWS_DEF = 14;
    localparam int TIME_BINS_DEF   = 200;

    // Energy and time constants in quarter units
    localparam int GATE_LOW   = 80;
    localparam int GATE_HIGH  = 3000;
    localparam int HIST_SPAN  = 4000;
    localparam int SPAN_W     = $clog2(HIST_SPAN);

    localparam logic [VAL_W-1:0] COUNT_MAX = '1;
    localparam logic [BIN_W-1:0] BIN_MAX   = '1;

    localparam logic [E_W-1:0] RST_WINDOW_START = 14'd400;
    localparam logic [E_W-1:0] RST_WINDOW_STEP  = 14'd200;
    localparam logic [E_W-1:0] RST_HALF_WIDTH   = 14'd100;
    localparam logic [E_W-1:0] RST_PEAK_LOW     = 14'd2600;
    localparam logic [E_W-1:0] RST_PEAK_HIGH    = 14'd3000;
    localparam logic [E_W-1:0] RST_SIDE_LOW     = 14'd40;
    localparam logic [E_W-1:0] RST_SIDE_HIGH    = 14'd1800;

    typedef enum logic [1:0] {
        ACT_EVENT     = 2'd0,
        ACT_READ_PEAK = 2'd1,
        ACT_READ_SIDE = 2'd2,
        ACT_READ_BIN  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_PEAK = 2'd1,
        CLS_SIDE = 2'd2
    } t_class;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_SELECT = 3'd0,
        REG_WINDOW_START   = 3'd1,
        REG_WINDOW_STEP    = 3'd2,
        REG_HALF_WIDTH     = 3'd3,
        REG_PEAK_LOW       = 3'd4,
        REG_PEAK_HIGH      = 3'd5,
        REG_SIDE_LOW       = 3'd6,
        REG_SIDE_HIGH      = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]       action;
        logic [E_W-1:0]   energy_first;
        logic [E_W-1:0]   energy_second;
        logic [E_W-1:0]   event_time;
        logic [IDX_W-1:0] read_index;
    } t_in_beat;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [HIT_W-1:0] window_hit;
        logic [1:0]       event_class;
        logic             time_gated;
    } t_out_beat;

    typedef struct packed {
        logic           channel_select;
        logic [E_W-1:0] window_start;
        logic [E_W-1:0] window_step;
        logic [E_W-1:0] window_half_width;
        logic [E_W-1:0] peak_low;
        logic [E_W-1:0] peak_high;
        logic [E_W-1:0] side_low;
        logic [E_W-1:0] side_high;
    } t_cfg;

    typedef struct packed {
        t_class kind;
        logic   gated;
    } t_cls_info;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_hist_ctl;

endpackage

[hw/rtl/twegh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module twegh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/twegh_classify.sv]
// Event classification: window hits, energy gates and time histogram bin.
module twegh_classify import twegh_pkg::*; #(
    parameter int NUM_WINDOWS = NUM_WINDOWS_DEF,
    parameter int TIME_BINS   = TIME_BINS_DEF
) (
    input  t_in_beat                           i_beat,
    input  t_cfg                               i_cfg,
    output logic [NUM_WINDOWS-1:0]             o_hit,
    output t_cls_info                          o_info,
    output logic [$clog2(TIME_BINS+1)-1:0]     o_bin
);

    localparam int HA = $clog2(TIME_BINS + 1);
    localparam int CW = E_W + $clog2(NUM_WINDOWS) + 1;
    // bin = t * TIME_BINS / HIST_SPAN, exact for t below HIST_SPAN
    localparam int BIN_SH = 24;
    localparam logic [39:0] BIN_MUL =
        ((40'(TIME_BINS) << BIN_SH) + 40'(HIST_SPAN) - 40'd1) / 40'(HIST_SPAN);

    logic [CW-1:0]  w_t;
    logic [CW-1:0]  w_half;
    logic [E_W-1:0] w_energy;
    logic           w_peak;
    logic           w_side;
    logic           w_gate_first;
    logic           w_gate_second;
    logic [39:0]    w_prod;

    assign w_t    = CW'(i_beat.event_time);
    assign w_half = CW'(i_cfg.window_half_width);

    genvar g;
    for (g = 0; g < NUM_WINDOWS; g++) begin : g_win
        logic [CW-1:0] w_center;
        if (g == 0) begin : g_origin
            assign w_center = '0;
        end else begin : g_offset
            assign w_center = CW'(i_cfg.window_start) + CW'(g) * CW'(i_cfg.window_step);
        end
        // open window, evaluated without wrap
        assign o_hit[g] = (w_t + w_half > w_center) && (w_t < w_center + w_half);
    end

    assign w_energy = i_cfg.channel_select ? i_beat.energy_second : i_beat.energy_first;
    assign w_peak   = (w_energy >= i_cfg.peak_low) && (w_energy <= i_cfg.peak_high);
    assign w_side   = (w_energy >= i_cfg.side_low) && (w_energy <= i_cfg.side_high);

    assign w_gate_first  = (i_beat.energy_first > E_W'(GATE_LOW)) &&
                           (i_beat.energy_first < E_W'(GATE_HIGH));
    assign w_gate_second = (i_beat.energy_second > E_W'(GATE_LOW)) &&
                           (i_beat.energy_second < E_W'(GATE_HIGH));

    always_comb begin
        o_info.gated = w_gate_first || w_gate_second;
        priority if (w_peak) begin
            o_info.kind = CLS_PEAK;
        end else if (w_side) begin
            o_info.kind = CLS_SIDE;
        end else begin
            o_info.kind = CLS_NONE;
        end
    end

    assign w_prod = 40'(i_beat.event_time[SPAN_W-1:0]) * BIN_MUL;
    assign o_bin  = (i_beat.event_time >= E_W'(HIST_SPAN)) ? HA'(TIME_BINS)
                                                          : HA'(w_prod >> BIN_SH);

endmodule

[hw/rtl/twegh_hist.sv]
// Time histogram store: RAM with per-bin valid bits, forwarding and saturating update.
module twegh_hist import twegh_pkg::*; #(
    parameter int TIME_BINS = TIME_BINS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_hist_ctl                          i_ctl,
    input  logic [$clog2(TIME_BINS+1)-1:0]     i_rd_addr,
    output logic [BIN_W-1:0]                   o_count
);

    localparam int HA = $clog2(TIME_BINS + 1);

    logic [TIME_BINS:0] r_vld;
    logic [HA-1:0]      r_addr;
    logic               r_vbit;
    logic               r_fwd_v;
    logic [HA-1:0]      r_fwd_addr;
    logic [BIN_W-1:0]   r_fwd_data;
    logic [BIN_W-1:0]   w_rdata;
    logic [BIN_W-1:0]   w_next;

    twegh_ram #(
        .WIDTH (BIN_W),
        .DEPTH (TIME_BINS + 1)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_en),
        .i_waddr (r_addr),
        .i_wdata (w_next),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rdata)
    );

    // a write on the read edge is missed by the RAM; take it from the forward copy
    always_comb begin
        if (r_fwd_v && (r_fwd_addr == r_addr)) begin
            o_count = r_fwd_data;
        end else if (r_vbit) begin
            o_count = w_rdata;
        end else begin
            o_count = '0;
        end
    end

    assign w_next = (o_count == BIN_MAX) ? o_count : o_count + BIN_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_fwd_v <= 1'b0;
        end else if (i_ctl.wr_en) begin
            r_vld[r_addr] <= 1'b1;
            r_fwd_v       <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_addr <= i_rd_addr;
            r_vbit <= r_vld[i_rd_addr];
        end
        if (i_ctl.wr_en) begin
            r_fwd_addr <= r_addr;
            r_fwd_data <= w_next;
        end
    end

endmodule

[hw/rtl/time_window_energy_gate_histogram_top.sv]
// Top level of the gated time-window histogram: stages, window counters, configuration.
//
// Input channel: i_in_valid / o_in_stall / i_in_beat. A beat is either an event
// (two energies and a time) or a read of a peak counter, a side counter or a
// time histogram bin. Output channel: o_out_valid / i_out_stall / o_out_beat,
// exactly one result beat per input beat, in order.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_data, one register per write; write
// only while no beat is in flight.
// Throughput: one beat per cycle unless the output stalls. Three register stages
// (input, histogram read, output) each move on when the next one is empty or
// draining, so a held result does not block the stages behind it until all
// three are full; a result is valid once it reaches the output register.
// The histogram update is a read-modify-write over the RAM's registered read
// port; the write-back of one beat is forwarded to the beat right behind it.
// Reset: all counters and the configuration return to defaults at once; histogram
// bins are cleared through per-bin valid bits, so there is no clearing pass and
// the block takes beats on the first cycle after reset.
// While i_out_stall holds, the output beat stays put and o_in_stall rises once
// all stages are occupied.
module time_window_energy_gate_histogram_top import twegh_pkg::*; #(
    parameter int NUM_WINDOWS = NUM_WINDOWS_DEF,
    parameter int TIME_BINS   = TIME_BINS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_beat             i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_beat            o_out_beat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [E_W-1:0]       i_cfg_data
);

    localparam int HA = $clog2(TIME_BINS + 1);
    localparam int WA = $clog2(NUM_WINDOWS);

    t_cfg                  r_cfg;
    logic                  r_s0_v;
    t_in_beat              r_s0;
    logic                  r_s1_v;
    logic [VAL_W-1:0]      r_s1_value;
    logic [HIT_W-1:0]      r_s1_hit;
    logic [1:0]            r_s1_cls;
    logic                  r_s1_gated;
    logic                  r_s1_bin_rd;
    logic                  r_s1_bin_ok;
    logic                  r_s2_v;
    t_out_beat             r_out;
    logic [VAL_W-1:0]      r_peak [NUM_WINDOWS];
    logic [VAL_W-1:0]      r_side [NUM_WINDOWS];

    logic                  w_s0_free;
    logic                  w_s1_free;
    logic                  w_s2_free;
    logic                  w_adv0;
    logic                  w_adv1;
    logic                  w_is_event;
    logic [NUM_WINDOWS-1:0] w_hit;
    t_cls_info             w_info;
    logic [HA-1:0]         w_bin;
    logic [HIT_W-1:0]      w_hit_idx;
    logic [VAL_W-1:0]      w_cnt_val;
    logic                  w_win_ok;
    t_hist_ctl             w_hist_ctl;
    logic [HA-1:0]         w_hist_addr;
    logic [BIN_W-1:0]      w_bin_count;
    logic [VAL_W-1:0]      w_s1_value;

    // Stage flow: each stage moves when the one after it is empty or moving
    assign w_s2_free  = !r_s2_v || !i_out_stall;
    assign w_s1_free  = !r_s1_v || w_s2_free;
    assign w_s0_free  = !r_s0_v || w_s1_free;
    assign w_adv0     = r_s0_v && w_s1_free;
    assign w_adv1     = r_s1_v && w_s2_free;
    assign o_in_stall = !w_s0_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_select    <= 1'b0;
            r_cfg.window_start      <= RST_WINDOW_START;
            r_cfg.window_step       <= RST_WINDOW_STEP;
            r_cfg.window_half_width <= RST_HALF_WIDTH;
            r_cfg.peak_low          <= RST_PEAK_LOW;
            r_cfg.peak_high         <= RST_PEAK_HIGH;
            r_cfg.side_low          <= RST_SIDE_LOW;
            r_cfg.side_high         <= RST_SIDE_HIGH;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_CHANNEL_SELECT: r_cfg.channel_select    <= i_cfg_data[0];
                REG_WINDOW_START:   r_cfg.window_start      <= i_cfg_data;
                REG_WINDOW_STEP:    r_cfg.window_step       <= i_cfg_data;
                REG_HALF_WIDTH:     r_cfg.window_half_width <= i_cfg_data;
                REG_PEAK_LOW:       r_cfg.peak_low          <= i_cfg_data;
                REG_PEAK_HIGH:      r_cfg.peak_high         <= i_cfg_data;
                REG_SIDE_LOW:       r_cfg.side_low          <= i_cfg_data;
                REG_SIDE_HIGH:      r_cfg.side_high         <= i_cfg_data;
                default:            r_cfg                   <= r_cfg;
            endcase
        end
    end

    // Stage 0: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_s0_free) begin
            r_s0_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s0_free && i_in_valid) begin
            r_s0 <= i_in_beat;
        end
    end

    twegh_classify #(
        .NUM_WINDOWS (NUM_WINDOWS),
        .TIME_BINS   (TIME_BINS)
    ) u_classify (
        .i_beat (r_s0),
        .i_cfg  (r_cfg),
        .o_hit  (w_hit),
        .o_info (w_info),
        .o_bin  (w_bin)
    );

    assign w_is_event = (t_action'(r_s0.action) == ACT_EVENT);

    // lowest window hit; NUM_WINDOWS when none
    always_comb begin
        w_hit_idx = HIT_W'(NUM_WINDOWS);
        for (int i = NUM_WINDOWS - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                w_hit_idx = HIT_W'(i);
            end
        end
    end

    assign w_win_ok = int'(r_s0.read_index) < NUM_WINDOWS;

    always_comb begin
        w_cnt_val = '0;
        unique case (t_action'(r_s0.action))
            ACT_READ_PEAK: begin
                if (w_win_ok) begin
                    w_cnt_val = r_peak[WA'(r_s0.read_index)];
                end
            end
            ACT_READ_SIDE: begin
                if (w_win_ok) begin
                    w_cnt_val = r_side[WA'(r_s0.read_index)];
                end
            end
            default: w_cnt_val = '0;
        endcase
    end

    // Window counters: every hit window counts the event's class
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WINDOWS; i++) begin
                r_peak[i] <= '0;
                r_side[i] <= '0;
            end
        end else if (w_adv0 && w_is_event) begin
            for (int i = 0; i < NUM_WINDOWS; i++) begin
                if (w_hit[i] && (w_info.kind == CLS_PEAK) && (r_peak[i] != COUNT_MAX)) begin
                    r_peak[i] <= r_peak[i] + VAL_W'(1);
                end
                if (w_hit[i] && (w_info.kind == CLS_SIDE) && (r_side[i] != COUNT_MAX)) begin
                    r_side[i] <= r_side[i] + VAL_W'(1);
                end
            end
        end
    end

    // Histogram store: read issued from stage 0, updated from stage 1
    assign w_hist_addr      = w_is_event ? w_bin : HA'(r_s0.read_index);
    assign w_hist_ctl.rd_en = w_adv0;
    assign w_hist_ctl.wr_en = w_adv1 && r_s1_gated;

    twegh_hist #(
        .TIME_BINS (TIME_BINS)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_hist_ctl),
        .i_rd_addr (w_hist_addr),
        .o_count   (w_bin_count)
    );

    // Stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_v <= r_s0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv0) begin
            r_s1_value  <= w_cnt_val;
            r_s1_hit    <= w_is_event ? w_hit_idx : HIT_W'(NUM_WINDOWS);
            r_s1_cls    <= (w_is_event && (|w_hit)) ? w_info.kind : CLS_NONE;
            r_s1_gated  <= w_is_event && w_info.gated;
            r_s1_bin_rd <= (t_action'(r_s0.action) == ACT_READ_BIN);
            r_s1_bin_ok <= int'(r_s0.read_index) <= TIME_BINS;
        end
    end

    assign w_s1_value = !r_s1_bin_rd ? r_s1_value :
                        (r_s1_bin_ok ? VAL_W'(w_bin_count) : '0);

    // Stage 2: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_s2_free) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_out.read_value  <= w_s1_value;
            r_out.window_hit  <= r_s1_hit;
            r_out.event_class <= r_s1_cls;
            r_out.time_gated  <= r_s1_gated;
        end
    end

    assign o_out_valid = r_s2_v;
    assign o_out_beat  = r_out;

    // Assertions
    a_hist_wr_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hist_ctl.wr_en |-> (r_s1_v && !r_s1_bin_rd))
        else $error("histogram written for a beat that is not a gated event");

    a_peak_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_peak[0] != $past(r_peak[0])))
            |-> (r_peak[0] == $past(r_peak[0]) + VAL_W'(1)))
        else $error("peak counter moved by other than one");

    a_event_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_beat.window_hit != HIT_W'(NUM_WINDOWS)))
            |-> (o_out_beat.read_value == '0))
        else $error("event result carries a read value");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s0_v && r_s1_v && r_s2_v))
        else $error("input stalled with a free stage");

endmodule

[tb/sv/testbench.sv]
// Self-checking bench for the gated time-window histogram: directed table, random beats, full-rate burst.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import twegh_pkg::*;

    localparam int NUM_WIN         = NUM_WINDOWS_DEF;
    localparam int HIST_BINS       = TIME_BINS_DEF;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int BURST_EVENTS    = 100;
    localparam int LONG_HOLD       = 80;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int N_DIRECTED      = 25;

    localparam logic TYPED = 1'b1;
    localparam logic MODEL = 1'b0;

    // value 0, no window, class none, not gated
    localparam t_out_beat IDLE_RESULT = {20'd0, 4'd14, CLS_NONE, 1'b0};
    localparam t_out_beat UNTYPED     = '0;

    localparam t_cfg RST_CFG = {1'b0, RST_WINDOW_START, RST_WINDOW_STEP, RST_HALF_WIDTH,
                                RST_PEAK_LOW, RST_PEAK_HIGH, RST_SIDE_LOW, RST_SIDE_HIGH};
    localparam t_cfg WIDE_CFG = {1'b0, 14'h3FFF, 14'h3FFF, 14'h3FFF,
                                 14'd0, 14'h3FFF, 14'd0, 14'h3FFF};
    localparam t_cfg STACKED_CFG = {1'b0, 14'd2000, 14'd0, 14'd300,
                                    14'd500, 14'd900, 14'd0, 14'h3FFF};

    typedef struct packed {
        t_in_beat  beat;
        logic      known;
        t_out_beat want;
    } t_probe;

    t_probe directed_rows [N_DIRECTED] = '{
        {ACT_READ_PEAK, 14'd0, 14'd0, 14'd0, 8'd0, TYPED, IDLE_RESULT},
        {ACT_READ_SIDE, 14'd0, 14'd0, 14'd0, 8'd13, TYPED, IDLE_RESULT},
        {ACT_READ_BIN, 14'd0, 14'd0, 14'd0, 8'd0, TYPED, IDLE_RESULT},
        {ACT_READ_BIN, 14'd0, 14'd0, 14'd0, 8'd200, TYPED, IDLE_RESULT},
        {ACT_READ_PEAK, 14'h3FFF, 14'h3FFF, 14'h3FFF, 8'd14, TYPED, IDLE_RESULT},
        {ACT_READ_SIDE, 14'd0, 14'd0, 14'd0, 8'd255, TYPED, IDLE_RESULT},
        {ACT_READ_BIN, 14'd0, 14'd0, 14'd0, 8'd201, TYPED, IDLE_RESULT},
        {ACT_EVENT, 14'd0, 14'd0, 14'd0, 8'd0, TYPED, {20'd0, 4'd0, CLS_NONE, 1'b0}},
        {ACT_EVENT, 14'h3FFF, 14'h3FFF, 14'h3FFF, 8'hFF, TYPED, IDLE_RESULT},
        {ACT_EVENT, 14'd2800, 14'd0, 14'd600, 8'd0, MODEL, UNTYPED},
        {ACT_EVENT, 14'd1000, 14'd5000, 14'd1000, 8'd0, MODEL, UNTYPED},
        {ACT_EVENT, 14'd2600, 14'd0, 14'd3000, 8'd0, MODEL, UNTYPED},
        {ACT_EVENT, 14'd3000, 14'd81, 14'd2999, 8'd0, MODEL, UNTYPED},
        {ACT_EVENT, 14'd40, 14'd80, 14'd20, 8'd0, MODEL, UNTYPED},
        {ACT_EVENT, 14'd1800, 14'd0, 14'd599, 8'd0, MODEL, UNTYPED},
        {ACT_EVENT, 14'd1801, 14'd2999, 14'd1400, 8'd0, MODEL, UNTYPED},
        // gate matches but the time sits on an open window edge
        {ACT_EVENT, 14'd2800, 14'd0, 14'd500, 8'd0, MODEL, UNTYPED},
        {ACT_EVENT, 14'd2800, 14'd2999, 14'd501, 8'd0, MODEL, UNTYPED},
        {ACT_EVENT, 14'd100, 14'd0, 14'd3999, 8'd0, MODEL, UNTYPED},
        {ACT_EVENT, 14'd2999, 14'd0, 14'd4000, 8'd0, MODEL, UNTYPED},
        {ACT_READ_PEAK, 14'd0, 14'd0, 14'd0, 8'd1, MODEL, UNTYPED},
        {ACT_READ_SIDE, 14'd0, 14'd0, 14'd0, 8'd3, MODEL, UNTYPED},
        {ACT_READ_BIN, 14'd0, 14'd0, 14'd0, 8'd200, MODEL, UNTYPED},
        {ACT_READ_BIN, 14'd0, 14'd0, 14'd0, 8'd199, MODEL, UNTYPED},
        {ACT_READ_PEAK, 14'd0, 14'd0, 14'd0, 8'd13, MODEL, UNTYPED}
    };

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_beat             i_in_beat  = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_beat            o_out_beat;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [E_W-1:0]       i_cfg_data = '0;

    t_cfg             gate_cfg = RST_CFG;
    logic [VAL_W-1:0] peak_tally [NUM_WIN];
    logic [VAL_W-1:0] side_tally [NUM_WIN];
    logic [BIN_W-1:0] time_bins  [HIST_BINS + 1];
    t_out_beat        owed_results [$];
    t_out_beat        owed_head;
    int               mismatch_count = 0;
    int               quiet_cycles   = 0;
    bit               in_idling      = 1'b1;
    bit               out_idling     = 1'b1;
    bit               hold_out_req   = 1'b0;

    time_window_energy_gate_histogram_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_beat (o_out_beat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Gate, window and histogram bookkeeping for one accepted beat.
    function automatic t_out_beat tally_beat(input t_in_beat b);
        t_out_beat      r;
        logic [E_W-1:0] e;
        t_class         kind;
        longint         centre, hw, tt;
        int             hit, bin, i;
        r = '0;
        hit = NUM_WIN;
        case (t_action'(b.action))
            ACT_EVENT: begin
                e = gate_cfg.channel_select ? b.energy_second : b.energy_first;
                kind = CLS_NONE;
                if (e >= gate_cfg.peak_low && e <= gate_cfg.peak_high) begin
                    kind = CLS_PEAK;
                end else if (e >= gate_cfg.side_low && e <= gate_cfg.side_high) begin
                    kind = CLS_SIDE;
                end
                if ((b.energy_first > GATE_LOW && b.energy_first < GATE_HIGH) ||
                    (b.energy_second > GATE_LOW && b.energy_second < GATE_HIGH)) begin
                    bin = (b.event_time >= HIST_SPAN) ? HIST_BINS
                        : int'(b.event_time) * HIST_BINS / HIST_SPAN;
                    if (time_bins[bin] != BIN_MAX) time_bins[bin] = time_bins[bin] + 1'b1;
                    r.time_gated = 1'b1;
                end
                hw = longint'(gate_cfg.window_half_width);
                tt = longint'(b.event_time);
                for (i = 0; i < NUM_WIN; i++) begin
                    centre = (i == 0) ? 0 : longint'(gate_cfg.window_start)
                             + longint'(i) * longint'(gate_cfg.window_step);
                    if (tt > centre - hw && tt < centre + hw) begin
                        if (hit == NUM_WIN) hit = i;
                        if (kind == CLS_PEAK && peak_tally[i] != COUNT_MAX) begin
                            peak_tally[i] = peak_tally[i] + 1'b1;
                        end else if (kind == CLS_SIDE && side_tally[i] != COUNT_MAX) begin
                            side_tally[i] = side_tally[i] + 1'b1;
                        end
                    end
                end
                if (hit != NUM_WIN) r.event_class = kind;
            end
            ACT_READ_PEAK: begin
                if (b.read_index < NUM_WIN) r.read_value = peak_tally[b.read_index];
            end
            ACT_READ_SIDE: begin
                if (b.read_index < NUM_WIN) r.read_value = side_tally[b.read_index];
            end
            default: begin
                if (b.read_index <= HIST_BINS) r.read_value = VAL_W'(time_bins[b.read_index]);
            end
        endcase
        r.window_hit = HIT_W'(hit);
        return r;
    endfunction

    // Energy close to one of the gate bounds, or anywhere.
    function automatic logic [E_W-1:0] near_edge_energy();
        int base;
        case ($urandom_range(0, 7))
            0: base = gate_cfg.peak_low;
            1: base = gate_cfg.peak_high;
            2: base = gate_cfg.side_low;
            3: base = gate_cfg.side_high;
            4: base = GATE_LOW;
            5: base = GATE_HIGH;
            default: return E_W'($urandom);
        endcase
        base = base + int'($urandom_range(0, 4)) - 2;
        if (base < 0) base = 0;
        if (base > 16383) base = 16383;
        return E_W'(base);
    endfunction

    function automatic t_in_beat draw_beat();
        t_in_beat b;
        int       pick, k, hw, t;
        b.action        = ACT_EVENT;
        b.energy_first  = E_W'($urandom);
        b.energy_second = E_W'($urandom);
        b.event_time    = E_W'($urandom);
        b.read_index    = IDX_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            if ($urandom_range(0, 3) != 0) b.energy_first = near_edge_energy();
            if ($urandom_range(0, 3) != 0) b.energy_second = near_edge_energy();
            if (pick >= 6) begin
                // aim at a random window, often right at its open edges
                k = $urandom_range(0, NUM_WIN - 1);
                hw = gate_cfg.window_half_width;
                t = (k == 0) ? 0 : int'(gate_cfg.window_start) + k * int'(gate_cfg.window_step);
                if ($urandom_range(0, 1)) begin
                    t = t + ($urandom_range(0, 1) ? hw : -hw) + int'($urandom_range(0, 4)) - 2;
                end else begin
                    t = t + int'($urandom_range(0, 2 * hw + 4)) - hw - 2;
                end
                if (t < 0) t = 0;
                if (t > 16383) t = 16383;
                b.event_time = E_W'(t);
            end
        end else if (pick < 80) begin
            b.action = $urandom_range(0, 1) ? ACT_READ_PEAK : ACT_READ_SIDE;
            if ($urandom_range(0, 7) != 0) b.read_index = IDX_W'($urandom_range(0, 15));
        end else begin
            b.action = ACT_READ_BIN;
            if ($urandom_range(0, 7) != 0) b.read_index = IDX_W'($urandom_range(0, HIST_BINS));
        end
        return b;
    endfunction

    // Offer one beat, hold it until taken, then log what it must produce.
    task automatic offer(input t_in_beat b, input logic known, input t_out_beat want);
        t_out_beat r;
        if (in_idling && !hold_out_req && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (o_in_stall);
        r = tally_beat(b);
        owed_results.push_back(known ? want : r);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_cfg(input t_cfg c);
        t_cfg_reg r;
        r = r.first();
        repeat (8) begin
            i_cfg_we  <= 1'b1;
            i_cfg_idx <= r;
            case (r)
                REG_CHANNEL_SELECT: i_cfg_data <= E_W'(c.channel_select);
                REG_WINDOW_START:   i_cfg_data <= c.window_start;
                REG_WINDOW_STEP:    i_cfg_data <= c.window_step;
                REG_HALF_WIDTH:     i_cfg_data <= c.window_half_width;
                REG_PEAK_LOW:       i_cfg_data <= c.peak_low;
                REG_PEAK_HIGH:      i_cfg_data <= c.peak_high;
                REG_SIDE_LOW:       i_cfg_data <= c.side_low;
                default:            i_cfg_data <= c.side_high;
            endcase
            @(posedge i_clk);
            r = r.next();
        end
        i_cfg_we <= 1'b0;
        gate_cfg = c;
    endtask

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // Result side: compare every accepted beat with the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %h", $time, o_out_beat);
                mismatch_count++;
            end else begin
                owed_head = owed_results.pop_front();
                check_field("read_value", owed_head.read_value, o_out_beat.read_value);
                check_field("window_hit", owed_head.window_hit, o_out_beat.window_hit);
                check_field("event_class", owed_head.event_class, o_out_beat.event_class);
                check_field("time_gated", owed_head.time_gated, o_out_beat.time_gated);
            end
        end
    end

    // Result side stalls: random bursts, plus one long hold on request.
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_out_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_out_req = 1'b0;
            end else if (out_idling && $urandom_range(0, 11) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_cfg c;
        int   k, p;
        for (k = 0; k < NUM_WIN; k++) begin
            peak_tally[k] = '0;
            side_tally[k] = '0;
        end
        for (k = 0; k <= HIST_BINS; k++) time_bins[k] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIRECTED; k++) begin
            offer(directed_rows[k].beat, directed_rows[k].known, directed_rows[k].want);
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                0: begin
                    c = RST_CFG;
                    c.channel_select = 1'b1;
                end
                1: c = WIDE_CFG;
                2: begin
                    c = '0;
                    c.channel_select = 1'b1;
                end
                3: begin
                    // inverted bounds: both gates empty
                    c = RST_CFG;
                    c.peak_low  = RST_PEAK_HIGH;
                    c.peak_high = RST_PEAK_LOW;
                    c.side_low  = RST_SIDE_HIGH;
                    c.side_high = RST_SIDE_LOW;
                end
                4: c = STACKED_CFG;
                default: begin
                    c.channel_select    = $urandom_range(0, 1);
                    c.window_start      = E_W'($urandom_range(0, 3000));
                    c.window_step       = E_W'($urandom_range(0, 600));
                    c.window_half_width = E_W'($urandom_range(0, 700));
                    c.peak_low          = E_W'($urandom_range(0, 3000));
                    c.peak_high         = c.peak_low + E_W'($urandom_range(0, 1500));
                    c.side_low          = E_W'($urandom_range(0, 3000));
                    c.side_high         = c.side_low + E_W'($urandom_range(0, 2500));
                end
            endcase
            load_cfg(c);
            // back up the pipe while beats keep coming
            if (p == 0) hold_out_req = 1'b1;
            repeat (ITEMS_PER_PHASE) offer(draw_beat(), MODEL, UNTYPED);
        end

        // Full rate from here on: hammer a single bin back to back, then read everything.
        settle();
        in_idling  = 1'b0;
        out_idling = 1'b0;
        load_cfg(RST_CFG);
        repeat (BURST_EVENTS) begin
            offer({ACT_EVENT, E_W'($urandom_range(81, 2999)), E_W'($urandom),
                   E_W'($urandom_range(100, 119)), IDX_W'($urandom)}, MODEL, UNTYPED);
        end
        for (k = 0; k <= HIST_BINS; k++) begin
            offer({ACT_READ_BIN, 14'd0, 14'd0, 14'd0, IDX_W'(k)}, MODEL, UNTYPED);
        end
        for (k = 0; k < NUM_WIN; k++) begin
            offer({ACT_READ_PEAK, 14'd0, 14'd0, 14'd0, IDX_W'(k)}, MODEL, UNTYPED);
            offer({ACT_READ_SIDE, 14'd0, 14'd0, 14'd0, IDX_W'(k)}, MODEL, UNTYPED);
        end
        settle();

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/twegh_pkg.sv
hw/rtl/twegh_ram.sv
hw/rtl/twegh_classify.sv
hw/rtl/twegh_hist.sv
hw/rtl/time_window_energy_gate_histogram_top.sv
tb/sv/testbench.sv
